// File: src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg: shared constants and types of the rms meter
// widths of the sample path, the frame sums and the divide and root units
// ----------------------------------------------------------------------------
package rms_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_LEN     = 65536;
   localparam int RMS_BITS    = 16;

   // a square of a full-scale negative sample needs 2*SAMPLE_BITS-1 bits
   localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
   localparam int CNT_BITS    = $clog2(MAX_LEN + 1);
   localparam int SUM_BITS    = SQ_BITS + $clog2(MAX_LEN);
   localparam int ROOT_BITS   = (SUM_BITS + 1) / 2;
   localparam int RAD_BITS    = 2 * ROOT_BITS;
   localparam int STEP_BITS   = $clog2(SUM_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // one finished frame handed from the accumulator to the divide/root side
   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [CNT_BITS-1:0] count;
      logic                too_long;
   } frame_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_DONE
   } back_state_type;

endpackage

// File: src/rms_req_if.sv
// ----------------------------------------------------------------------------
// rms_req_if: sample request channel
// valid/ready channel carrying one signed sample and the end-of-frame mark
// ----------------------------------------------------------------------------
interface rms_req_if import rms_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: src/rms_rsp_if.sv
// ----------------------------------------------------------------------------
// rms_rsp_if: result channel
// valid/ready channel carrying one rms value and the truncation flag
// ----------------------------------------------------------------------------
interface rms_rsp_if import rms_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RMS_BITS-1:0] rms;
   logic                too_long;

   modport source (output valid, output rms, output too_long, input ready);
   modport sink   (input valid, input rms, input too_long, output ready);
endinterface

// File: src/rms_meter.sv
// ----------------------------------------------------------------------------
// rms_meter: frame rms meter
// per-frame root mean square of signed q1.15 samples
// ----------------------------------------------------------------------------
// Samples enter at one request per cycle while the frame queue has room. Each
// sample is squared, registered, and added to a 47-bit frame sum with a 17-bit
// count; once 65536 samples are counted the rest of the frame is dropped and
// too_long is set. The request marked last closes the frame and its totals go
// into a two-entry queue. The back unit pops a frame and runs a restoring divide
// (one quotient bit per cycle), then a square root (one root bit per cycle), then
// hands the result to the output register once that register is free. A new
// frame is taken only after the previous result is handed on. When frames close
// faster than the back unit drains them, the queue fills and the request side
// waits on the closing sample. The result is floor(sqrt(floor(sum / count))) in
// unsigned q1.15, at most 0x8000.
// ----------------------------------------------------------------------------
module rms_meter import rms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rms_req_if.sink   req_bus,
   rms_rsp_if.source rsp_bus
);

   // frame totals from the accumulator into the queue
   logic      push_valid;
   logic      push_ready;
   frame_type push_frame;

   // queue head toward the divide/root unit
   logic      pop_valid;
   logic      pop_ready;
   frame_type pop_frame;

   // accumulator: squares, sums and counts one sample per cycle unless a closing sample waits on a full queue
   rms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_frame (push_frame)
   );

   // decouples frame closing from the multi-cycle back unit
   rms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   // divide, square root and output register
   rms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_frame (pop_frame),
      .rsp_bus   (rsp_bus)
   );

   // the accumulator never closes a frame into a full queue
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("frame pushed into full queue");

   // after taking a frame the back unit leaves idle and is no longer ready for another
   a_pop_has_frame: assert property (@(posedge clock) disable iff (reset)
      (pop_ready && pop_valid) |=> !pop_ready)
      else $error("back unit took a frame without leaving idle");

   // a counted frame always has a nonzero divisor
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_frame.count != '0))
      else $error("frame closed with zero count");

   // no result is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

// File: src/rms_front.sv
// ----------------------------------------------------------------------------
// rms_front: sample accumulator
// squares each sample, sums squares and counts samples per frame
// ----------------------------------------------------------------------------
module rms_front import rms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rms_req_if.sink   req_bus,
   input  logic      push_ready,
   output logic      push_valid,
   output frame_type push_frame
);

   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] prod;
   logic                     accepted;
   logic                     s1_go;
   logic                     count_full;

   logic                     s1_valid_ff;
   logic                     s1_last_ff;
   logic [SQ_BITS-1:0]       s1_sq_ff;

   logic [SUM_BITS-1:0]      sum_ff;
   logic [SUM_BITS-1:0]      sum_in;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic [CNT_BITS-1:0]      cnt_in;
   logic                     ovf_ff;
   logic                     ovf_in;

   // magnitude as unsigned, full-scale negative wraps to 2^(SAMPLE_BITS-1)
   assign mag  = req_bus.sample[SAMPLE_BITS-1] ? (~req_bus.sample + 1'b1) : req_bus.sample;
   assign prod = mag * mag;

   // a last sample can only retire when the frame queue has room
   assign s1_go         = s1_valid_ff && (!s1_last_ff || push_ready);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign accepted      = req_bus.valid && req_bus.ready;

   assign count_full = (cnt_ff == CNT_BITS'(MAX_LEN));
   assign sum_in     = count_full ? sum_ff : (sum_ff + SUM_BITS'(s1_sq_ff));
   assign cnt_in     = count_full ? cnt_ff : (cnt_ff + 1'b1);
   assign ovf_in     = ovf_ff | count_full;

   assign push_valid          = s1_go && s1_last_ff;
   assign push_frame.sum      = sum_in;
   assign push_frame.count    = cnt_in;
   assign push_frame.too_long = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= accepted;
         end
         if (s1_go) begin
            if (s1_last_ff) begin
               sum_ff <= '0;
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               cnt_ff <= cnt_in;
               ovf_ff <= ovf_in;
            end
         end
      end
   end

   // square and mark, registered before the add
   always_ff @(posedge clock) begin
      if (accepted) begin
         s1_sq_ff   <= prod[SQ_BITS-1:0];
         s1_last_ff <= req_bus.last;
      end
   end

endmodule

// File: src/rms_queue.sv
// ----------------------------------------------------------------------------
// rms_queue: frame queue
// short fifo of finished frame totals between accumulator and divide/root
// ----------------------------------------------------------------------------
module rms_queue import rms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  frame_type push_frame,
   output logic      pop_valid,
   input  logic      pop_ready,
   output frame_type pop_frame
);

   frame_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCNT_BITS-1:0]   fill_ff;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (fill_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_frame  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// File: src/rms_back.sv
// ----------------------------------------------------------------------------
// rms_back: mean and root unit
// restoring divide of sum by count, then digit-by-digit square root
// ----------------------------------------------------------------------------
module rms_back import rms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  frame_type pop_frame,
   rms_rsp_if.source rsp_bus
);

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [STEP_BITS-1:0]   step_ff;

   logic [SUM_BITS-1:0]    dvd_ff;
   logic [CNT_BITS-1:0]    drem_ff;
   logic [CNT_BITS-1:0]    divisor_ff;
   logic                   ovf_ff;
   logic [RAD_BITS-1:0]    rad_ff;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [ROOT_BITS+1:0]   srem_ff;

   logic                   out_valid_ff;
   logic [RMS_BITS-1:0]    out_rms_ff;
   logic                   out_long_ff;

   logic [CNT_BITS:0]      drem_sh;
   logic [CNT_BITS:0]      drem_sub;
   logic                   div_ge;
   logic [SUM_BITS-1:0]    quot_in;
   logic [ROOT_BITS+1:0]   srem_sh;
   logic [ROOT_BITS+1:0]   trial;
   logic                   sq_ge;

   logic                   div_last;
   logic                   sqrt_last;
   logic                   load_out;

   // one quotient bit per cycle, shifted into the dividend register
   assign drem_sh  = {drem_ff, dvd_ff[SUM_BITS-1]};
   assign div_ge   = (drem_sh >= {1'b0, divisor_ff});
   assign drem_sub = drem_sh - {1'b0, divisor_ff};
   assign quot_in  = {dvd_ff[SUM_BITS-2:0], div_ge};

   // one root bit per cycle from two radicand bits
   assign srem_sh = {srem_ff[ROOT_BITS-1:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign sq_ge   = (srem_sh >= trial);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (pop_valid) state_in = BK_DIV;
         BK_DIV:  if (step_ff == STEP_BITS'(SUM_BITS - 1)) state_in = BK_SQRT;
         BK_SQRT: if (step_ff == STEP_BITS'(ROOT_BITS - 1)) state_in = BK_DONE;
         BK_DONE: if (!out_valid_ff || rsp_bus.ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      div_last  = 1'b0;
      sqrt_last = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop_ready = 1'b1;
         BK_DIV:  div_last  = (step_ff == STEP_BITS'(SUM_BITS - 1));
         BK_SQRT: sqrt_last = (step_ff == STEP_BITS'(ROOT_BITS - 1));
         BK_DONE: load_out  = !out_valid_ff || rsp_bus.ready;
         default: pop_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_last || sqrt_last || (state_ff == BK_IDLE)) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               dvd_ff     <= pop_frame.sum;
               divisor_ff <= pop_frame.count;
               ovf_ff     <= pop_frame.too_long;
               drem_ff    <= '0;
            end
         end
         BK_DIV: begin
            dvd_ff  <= quot_in;
            drem_ff <= div_ge ? drem_sub[CNT_BITS-1:0] : drem_sh[CNT_BITS-1:0];
            if (div_last) begin
               rad_ff  <= RAD_BITS'(quot_in);
               root_ff <= '0;
               srem_ff <= '0;
            end
         end
         BK_SQRT: begin
            rad_ff  <= {rad_ff[RAD_BITS-3:0], 2'b00};
            srem_ff <= sq_ge ? (srem_sh - trial) : srem_sh;
            root_ff <= {root_ff[ROOT_BITS-2:0], sq_ge};
         end
         BK_DONE: begin
            if (load_out) begin
               out_rms_ff  <= root_ff[RMS_BITS-1:0];
               out_long_ff <= ovf_ff;
            end
         end
         default: begin
            drem_ff <= drem_ff;
         end
      endcase
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.rms      = out_rms_ff;
   assign rsp_bus.too_long = out_long_ff;

endmodule

// File: sim/rms_checker.sv
// ----------------------------------------------------------------------------
// rms_checker: result predictor and scoreboard for the rms meter
// watches both channels, keeps its own frame totals and checks each result
// ----------------------------------------------------------------------------
module rms_checker import rms_pkg::*; (
   input  logic clock,
   input  logic reset,
   rms_req_if   req_mon,
   rms_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_due
);

   typedef struct packed {
      logic [RMS_BITS-1:0] rms;
      logic                too_long;
   } rms_result_type;

   rms_result_type       expected_rms[$];
   logic [63:0]          frame_sum;
   logic [CNT_BITS-1:0]  frame_count;
   logic                 frame_dropped;

   // largest root whose square does not exceed the mean
   function automatic logic [31:0] floor_sqrt(input logic [63:0] mean);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= mean)
            root = trial;
      end
      return root;
   endfunction

   always @(posedge clock) begin
      rms_result_type seen;
      rms_result_type want;
      logic [63:0]    square;
      if (reset) begin
         expected_rms.delete();
         frame_sum     = '0;
         frame_count   = '0;
         frame_dropped = 1'b0;
         fail_count    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rms: rsp_mon.rms, too_long: rsp_mon.too_long};
            if (expected_rms.size() == 0) begin
               $error("unexpected result: rms=%0d too_long=%0d", seen.rms, seen.too_long);
               fail_count++;
            end else begin
               want = expected_rms.pop_front();
               if (seen.rms !== want.rms) begin
                  $error("rms: expected %0d, got %0d", want.rms, seen.rms);
                  fail_count++;
               end
               if (seen.too_long !== want.too_long) begin
                  $error("too_long: expected %0d, got %0d", want.too_long, seen.too_long);
                  fail_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            square = 64'(longint'(req_mon.sample) * longint'(req_mon.sample));
            if (frame_count < MAX_LEN) begin
               if (frame_sum > ~64'd0 - square)
                  frame_sum = '1;
               else
                  frame_sum += square;
               frame_count++;
            end else begin
               frame_dropped = 1'b1;
            end
            if (req_mon.last) begin
               expected_rms.push_back('{rms:      RMS_BITS'(floor_sqrt(frame_sum / frame_count)),
                                        too_long: frame_dropped});
               frame_sum     = '0;
               frame_count   = '0;
               frame_dropped = 1'b0;
            end
         end
      end
      results_due = expected_rms.size();
   end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: frame rms meter test
// directed frames for the corner values, then random frames under random
// sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module testbench;
   import rms_pkg::*;

   // cycles with no handshake on either side before the run is declared hung;
   // the back end works on one frame at a time behind a two-frame queue
   localparam int IDLE_LIMIT = 5000;
   // settle time after the last result
   localparam int DRAIN_CYCLES = 150;

   typedef enum int {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_HALF,
      RDY_SPARSE
   } ready_mode_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   results_due;
   int   burst_left;
   int   idle_cycles;

   rms_req_if req_ch();
   rms_rsp_if rsp_ch();

   rms_meter u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   rms_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      req_ch.last   <= 1'b0;
   end

   // one request; called at a falling edge, returns at the falling edge after
   // acceptance with valid still high so a burst can continue back to back
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input logic closes);
      int gap;
      if (burst_left == 0) begin
         // end of burst: pick the next burst length and drop valid for a random gap
         gap = $urandom_range(1, 10);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(100, 400);   // long stretch with no gaps
         else
            burst_left = $urandom_range(1, 24);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.sample <= value;
      req_ch.last   <= closes;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // a run of equal samples, the final one optionally closing the frame
   task automatic send_run(input logic signed [SAMPLE_BITS-1:0] value,
                           input int count, input logic closes);
      for (int k = 0; k < count; k++)
         send_sample(value, closes && (k == count - 1));
   endtask

   // hold off the sender until every expected result has come back
   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
   endtask

   // receiver: ready follows a mode picked at random for each run
   initial begin
      ready_mode_type mode;
      int             run;
      int             phase;
      rsp_ch.ready <= 1'b0;
      phase = 0;
      forever begin
         mode = ready_mode_type'($urandom_range(0, 3));
         run  = $urandom_range(20, 120);
         repeat (run) begin
            @(negedge clock);
            phase++;
            case (mode)
               RDY_ALWAYS: rsp_ch.ready <= 1'b1;
               RDY_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RDY_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) != 0);
               default:    rsp_ch.ready <= (phase % 16 == 15);   // long stalls
            endcase
         end
      end
   end

   // hang detection: count cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** rms_meter: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int                            frame_len;
      int                            random_items;
      int                            random_frames;
      int                            pick;
      logic signed [SAMPLE_BITS-1:0] value;

      burst_left    = 0;
      random_items  = 0;
      random_frames = 0;

      // reset held, then released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-sample frames at the field extremes
      send_run(16'sd0, 1, 1'b1);
      send_run(-16'sd32768, 1, 1'b1);   // largest result, 0x8000
      send_run(16'sd32767, 1, 1'b1);
      send_run(16'sd1, 1, 1'b1);
      send_run(-16'sd1, 1, 1'b1);

      // short frames: both extremes together, alternating bit patterns, a mix
      send_run(16'sd32767, 1, 1'b0);
      send_run(-16'sd32768, 1, 1'b1);
      send_run(16'sh5555, 1, 1'b0);
      send_run(-16'sd21846, 2, 1'b1);   // 0xaaaa twice
      send_run(16'sd3, 1, 1'b0);
      send_run(-16'sd4, 1, 1'b0);
      send_run(16'sd5, 1, 1'b1);

      // pause the sender until everything so far has come out
      wait_results_done();

      // random frames, mostly short, some long enough to keep intake busy
      while (random_items < 480) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            frame_len = $urandom_range(1, 12);
         else if (pick < 19)
            frame_len = $urandom_range(13, 80);
         else
            frame_len = $urandom_range(81, 300);

         for (int k = 0; k < frame_len; k++) begin
            case ($urandom_range(0, 9))
               0:       value = -16'sd32768;
               1:       value = 16'sd32767;
               2:       value = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
               3:       value = 16'sd0;
               default: value = SAMPLE_BITS'($urandom);
            endcase
            send_sample(value, k == frame_len - 1);
         end
         random_items += frame_len;
         random_frames++;

         // now and then let the pipeline run dry between frames
         if (random_frames % 15 == 0)
            wait_results_done();
      end

      // everything sent: wait for the last results, then settle
      wait_results_done();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && results_due == 0)
         $display("** rms_meter: PASSED **");
      else
         $display("** rms_meter: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
src/rms_pkg.sv
src/rms_req_if.sv
src/rms_rsp_if.sv
src/rms_front.sv
src/rms_queue.sv
src/rms_back.sv
src/rms_meter.sv
sim/rms_checker.sv
sim/testbench.sv
